### hdl/ray_sphere_plane_intersect_core_assert.svh
// Assertion macros for the ray caster checker.
`ifndef RAY_SPHERE_PLANE_INTERSECT_CORE_ASSERT_SVH
`define RAY_SPHERE_PLANE_INTERSECT_CORE_ASSERT_SVH

// Implication checked in the same cycle.
`define RSPI_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define RSPI_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/rspi_pkg.sv
`default_nettype none
package rspi_pkg;

  localparam int FRAC_BITS = 16;
  localparam longint ONE = longint'(1) << FRAC_BITS;

  localparam int S_DATA_W = 192;
  localparam int M_DATA_W = 192;

  typedef logic [S_DATA_W-1:0] s_data_t;
  typedef logic [M_DATA_W-1:0] m_data_t;

  typedef struct packed {
    logic [3:0]          material;
    logic [30:0]         radius;
    logic signed [31:0]  cz;
    logic signed [31:0]  cy;
    logic signed [31:0]  cx;
  } sphere_t;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RAY  = 1'b1;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_SPHERE = 2'd1;
  localparam logic [1:0] KIND_PLANE  = 2'd2;

  localparam longint PLANE_Y_OFF = 4 * ONE;
  localparam longint X_LIM       = 10 * ONE;
  localparam longint Z_NEAR      = -10 * ONE;
  localparam longint Z_FAR       = -30 * ONE;
  localparam longint HIT_LIM     = 1000 * ONE;
  localparam longint CHK_OFF     = 2000 * ONE;
  localparam longint PLANE_TH    = ONE / 1000;
  localparam longint D_CLAMP     = longint'(1) << 40;
  localparam longint N_MAX       = 131071;
  localparam longint N_MIN       = -131072;

endpackage
`default_nettype wire

### hdl/rspi_sqrt.sv
`default_nettype none
module rspi_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [4:0]  step;
  logic [63:0] n;
  logic [33:0] rem;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;

  assign rem_sh = {rem, n[63:62]};
  assign trial  = {2'b00, root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        n    <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rem  <= ge ? 34'(rem_sh - trial) : 34'(rem_sh);
        root <= {root[30:0], ge};
        n    <= {n[61:0], 2'b00};
        step <= step + 5'd1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hdl/rspi_div.sv
`default_nettype none
module rspi_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [49:0] dividend,
  input  logic signed [32:0] divisor,
  output logic               done,
  output logic signed [50:0] quotient
);

  logic        busy;
  logic [5:0]  step;
  logic        neg;
  logic [49:0] acc;
  logic [32:0] dsr;
  logic [32:0] rem;
  logic [33:0] rem_sh;
  logic        ge;

  assign rem_sh   = {rem, acc[49]};
  assign ge       = rem_sh >= {1'b0, dsr};
  assign quotient = neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});

  // Restoring division on magnitudes; the quotient bits shift into acc.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        neg  <= dividend[49] ^ divisor[32];
        acc  <= dividend[49] ? 50'(-dividend) : 50'(dividend);
        dsr  <= divisor[32] ? 33'(-divisor) : 33'(divisor);
        rem  <= '0;
      end else if (busy) begin
        rem  <= ge ? 33'(rem_sh - {1'b0, dsr}) : 33'(rem_sh);
        acc  <= {acc[48:0], ge};
        step <= step + 6'd1;
        if (step == 6'd49) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hdl/ray_sphere_plane_intersect_core.sv
`default_nettype none
// Nearest-hit ray caster over a sphere table and a bounded checkerboard plane.
// Input beats on s_*: tuser is func (0 load a sphere, 1 cast a ray). A load beat
// writes the sphere table at entry_index and returns one all-zero result beat.
// A ray beat returns one beat with the nearest hit, its normal and material.
// The register sphere_count must be written through cfg_we/cfg_wdata only while
// idle; the block itself does not enforce this. One item is worked at a time.
// A ray runs a bounding test on each sphere, takes the roots of each sphere that
// passes it with a 32-step square root, and for each sphere that becomes the
// nearest hit works its normal with a 32-step square root and three 50-step
// divisions. The plane test adds one 50-step division when the ray is not flat.
// The result sits in an output register; the next item is accepted while it
// waits for m_tready, and the block stalls only when a second result is ready.
// Reset clears the control state and sphere_count. The table is not cleared;
// a ray must only reach entries that were loaded.
module ray_sphere_plane_intersect_core #(
  parameter int MAX_SPHERES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata,
  input  logic              s_tvalid,
  output logic              s_tready,
  // entry_index, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, radius, sphere_material
  input  rspi_pkg::s_data_t s_tdata,
  // func
  input  logic              s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // hit, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z, hit_material,
  // checker_shade, hit_distance
  output rspi_pkg::m_data_t m_tdata,
  // hit_kind
  output logic [1:0]        m_tuser
);
  import rspi_pkg::*;

  localparam int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CNT_W = $clog2(MAX_SPHERES + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RD    = 5'd1;
  localparam logic [4:0] S_L     = 5'd2;
  localparam logic [4:0] S_DOT   = 5'd3;
  localparam logic [4:0] S_TCA   = 5'd4;
  localparam logic [4:0] S_SQ    = 5'd5;
  localparam logic [4:0] S_CMP   = 5'd6;
  localparam logic [4:0] S_THC   = 5'd7;
  localparam logic [4:0] S_T     = 5'd8;
  localparam logic [4:0] S_PT    = 5'd9;
  localparam logic [4:0] S_V     = 5'd10;
  localparam logic [4:0] S_SS    = 5'd11;
  localparam logic [4:0] S_LEN   = 5'd12;
  localparam logic [4:0] S_LENW  = 5'd13;
  localparam logic [4:0] S_NRM   = 5'd14;
  localparam logic [4:0] S_NRMW  = 5'd15;
  localparam logic [4:0] S_PLANE = 5'd16;
  localparam logic [4:0] S_PDIV  = 5'd17;
  localparam logic [4:0] S_PQ    = 5'd18;
  localparam logic [4:0] S_PCHK  = 5'd19;
  localparam logic [4:0] S_FIN   = 5'd20;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  logic [4:0]         state;
  logic [3:0]         sphere_count;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   idx;
  logic [1:0]         k;
  logic [1:0]         ki;
  logic [1:0]         kp;
  logic               is_ray;

  logic signed [31:0] s_pos [3];
  logic signed [17:0] s_dir [3];
  logic [2:0]         s_entry;
  logic               accept;

  sphere_t            mem [MAX_SPHERES];
  sphere_t            wentry;
  sphere_t            rd;
  logic [IDX_W-1:0]   waddr;
  logic               mem_we;
  logic               mem_re;
  logic signed [31:0] cen [3];

  logic signed [31:0] org [3];
  logic signed [17:0] dv [3];
  logic signed [31:0] l [3];
  logic signed [51:0] acc;
  logic [48:0]        ll;
  logic signed [31:0] tca;
  logic [47:0]        d2;
  logic [45:0]        r2;
  logic [31:0]        thc;
  logic signed [33:0] t;
  logic               sph;
  logic signed [41:0] best;
  logic signed [41:0] d;
  logic [1:0]         kind;
  logic [3:0]         mat;
  logic               shade;
  logic signed [31:0] pt [3];
  logic signed [31:0] v [3];
  logic signed [31:0] q [3];
  logic signed [17:0] nv [3];
  logic [63:0]        ss;
  logic [31:0]        len;

  logic signed [42:0] mula_a;
  logic signed [17:0] mula_b;
  logic signed [32:0] mulb_a;
  logic signed [32:0] mulb_b;
  logic signed [60:0] prod_a;
  logic signed [65:0] prod_b;

  logic signed [50:0] d2w;
  logic signed [33:0] tm;
  logic signed [33:0] tp;
  logic signed [33:0] tsel;
  logic [17:0]        ady;
  logic signed [49:0] pdvd;

  logic               sqrt_start;
  logic [63:0]        sqrt_rad;
  logic               sqrt_done;
  logic [31:0]        sqrt_root;
  logic               div_start;
  logic signed [49:0] div_dvd;
  logic signed [32:0] div_dsr;
  logic               div_done;
  logic signed [50:0] div_q;
  logic signed [41:0] d_cl;
  logic signed [17:0] n_cl;

  logic               pl_ok;
  logic signed [33:0] a_sum;
  logic signed [33:0] nq;
  logic               hit_flag;
  logic [30:0]        hit_dist;

  assign s_entry  = s_tdata[2:0];
  assign s_pos[0] = s_tdata[34:3];
  assign s_pos[1] = s_tdata[66:35];
  assign s_pos[2] = s_tdata[98:67];
  assign s_dir[0] = s_tdata[116:99];
  assign s_dir[1] = s_tdata[134:117];
  assign s_dir[2] = s_tdata[152:135];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign wentry.cx       = s_pos[0];
  assign wentry.cy       = s_pos[1];
  assign wentry.cz       = s_pos[2];
  assign wentry.radius   = s_tdata[183:153];
  assign wentry.material = s_tdata[187:184];
  assign waddr  = IDX_W'(s_entry);
  assign mem_we = accept && (s_tuser == FUNC_LOAD) && (32'(s_entry) < MAX_SPHERES);
  assign mem_re = (state == S_RD) && (idx != cnt);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wentry;
    end
    if (mem_re) begin
      rd <= mem[idx[IDX_W-1:0]];
    end
  end

  assign cen[0] = rd.cx;
  assign cen[1] = rd.cy;
  assign cen[2] = rd.cz;

  assign ki = (k == 2'd3) ? 2'd0 : k;
  assign kp = k - 2'd1;

  always_comb begin
    mula_a = '0;
    mula_b = dv[ki];
    mulb_a = '0;
    mulb_b = '0;
    case (state)
      S_DOT: begin
        mula_a = 43'(l[ki]);
        mulb_a = 33'(l[ki]);
        mulb_b = 33'(l[ki]);
      end
      S_SQ: begin
        mulb_a = (k == 2'd0) ? 33'(tca) : $signed({2'b00, rd.radius});
        mulb_b = mulb_a;
      end
      S_PT: mula_a = 43'(t);
      S_SS: begin
        mulb_a = 33'(v[ki]);
        mulb_b = 33'(v[ki]);
      end
      S_PQ: mula_a = 43'(d);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_a <= mula_a * mula_b;
    prod_b <= mulb_a * mulb_b;
  end

  assign d2w  = $signed({2'b00, ll}) - 51'(prod_b >>> FRAC_BITS);
  assign tm   = 34'(tca) - $signed({2'b00, thc});
  assign tp   = 34'(tca) + $signed({2'b00, thc});
  assign tsel = tm[33] ? tp : tm;
  assign ady  = dv[1][17] ? 18'(-dv[1]) : 18'(dv[1]);
  assign pdvd = -((50'(org[1]) + 50'(PLANE_Y_OFF)) <<< FRAC_BITS);

  assign sqrt_start = ((state == S_CMP) && (d2 <= 48'(r2))) || (state == S_LEN);
  assign sqrt_rad   = (state == S_CMP) ? (64'(48'(r2) - d2) << FRAC_BITS) : ss;
  assign div_start  = (state == S_NRM) || ((state == S_PLANE) && (ady > PLANE_TH));
  assign div_dvd    = (state == S_PLANE) ? pdvd : (50'(v[ki]) <<< FRAC_BITS);
  assign div_dsr    = (state == S_PLANE) ? 33'(dv[1]) : $signed({1'b0, len});

  rspi_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  rspi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    if (div_q > D_CLAMP) begin
      d_cl = 42'(D_CLAMP);
    end else if (div_q < -D_CLAMP) begin
      d_cl = 42'(-D_CLAMP);
    end else begin
      d_cl = div_q[41:0];
    end
    if (div_q > N_MAX) begin
      n_cl = 18'(N_MAX);
    end else if (div_q < N_MIN) begin
      n_cl = 18'(N_MIN);
    end else begin
      n_cl = div_q[17:0];
    end
  end

  assign pl_ok = (d > 0) && (q[0] < X_LIM) && (q[0] > -X_LIM) && (q[2] < Z_NEAR)
              && (q[2] > Z_FAR) && (!sph || (d < best));
  assign a_sum = 34'(q[0]) + 34'(CHK_OFF);
  assign nq    = -(34'(q[2]));

  assign hit_flag = (kind != KIND_NONE) && (best < HIT_LIM);
  always_comb begin
    if (kind != KIND_NONE) begin
      hit_dist = (best > 42'sd2147483647) ? '1 : best[30:0];
    end else begin
      hit_dist = is_ray ? '1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sphere_count <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        sphere_count <= cfg_wdata;
      end
      if (m_tvalid && m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            for (int i = 0; i < 3; i++) begin
              org[i] <= s_pos[i];
              dv[i]  <= s_dir[i];
              pt[i]  <= '0;
              nv[i]  <= '0;
            end
            is_ray <= s_tuser;
            sph    <= 1'b0;
            best   <= '0;
            kind   <= KIND_NONE;
            mat    <= '0;
            shade  <= 1'b0;
            idx    <= '0;
            if (32'(sphere_count) > MAX_SPHERES) begin
              cnt <= CNT_W'(MAX_SPHERES);
            end else begin
              cnt <= CNT_W'(sphere_count);
            end
            state <= (s_tuser == FUNC_RAY) ? S_RD : S_FIN;
          end
        end
        S_RD: begin
          state <= (idx == cnt) ? S_PLANE : S_L;
        end
        S_L: begin
          for (int i = 0; i < 3; i++) begin
            l[i] <= sat32(64'(cen[i]) - 64'(org[i]));
          end
          acc   <= '0;
          ll    <= '0;
          k     <= '0;
          state <= S_DOT;
        end
        S_DOT: begin
          k <= k + 2'd1;
          if (k != 2'd0) begin
            acc <= acc + 52'(prod_a);
            ll  <= ll + 49'(prod_b >>> FRAC_BITS);
          end
          if (k == 2'd3) begin
            state <= S_TCA;
          end
        end
        S_TCA: begin
          tca   <= sat32(64'(acc >>> FRAC_BITS));
          k     <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          k <= k + 2'd1;
          if (k == 2'd1) begin
            d2 <= d2w[50] ? '0 : d2w[47:0];
          end
          if (k == 2'd2) begin
            r2 <= 46'(prod_b >>> FRAC_BITS);
          end
          if (k == 2'd3) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (d2 > 48'(r2)) begin
            idx   <= idx + CNT_W'(1);
            state <= S_RD;
          end else begin
            state <= S_THC;
          end
        end
        S_THC: begin
          if (sqrt_done) begin
            thc   <= sqrt_root;
            state <= S_T;
          end
        end
        S_T: begin
          if (tsel[33] || (sph && (42'(tsel) >= best))) begin
            idx   <= idx + CNT_W'(1);
            state <= S_RD;
          end else begin
            sph   <= 1'b1;
            best  <= 42'(tsel);
            t     <= tsel;
            kind  <= KIND_SPHERE;
            mat   <= rd.material;
            k     <= '0;
            state <= S_PT;
          end
        end
        S_PT: begin
          k <= k + 2'd1;
          if (k != 2'd0) begin
            pt[kp] <= sat32(64'(org[kp]) + 64'(prod_a >>> FRAC_BITS));
          end
          if (k == 2'd3) begin
            state <= S_V;
          end
        end
        S_V: begin
          for (int i = 0; i < 3; i++) begin
            v[i] <= sat32(64'(pt[i]) - 64'(cen[i]));
          end
          ss    <= '0;
          k     <= '0;
          state <= S_SS;
        end
        S_SS: begin
          k <= k + 2'd1;
          if (k != 2'd0) begin
            ss <= ss + 64'(prod_b);
          end
          if (k == 2'd3) begin
            state <= S_LEN;
          end
        end
        S_LEN: begin
          state <= S_LENW;
        end
        S_LENW: begin
          if (sqrt_done) begin
            len <= sqrt_root;
            k   <= '0;
            if (sqrt_root == '0) begin
              for (int i = 0; i < 3; i++) begin
                nv[i] <= '0;
              end
              idx   <= idx + CNT_W'(1);
              state <= S_RD;
            end else begin
              state <= S_NRM;
            end
          end
        end
        S_NRM: begin
          state <= S_NRMW;
        end
        S_NRMW: begin
          if (div_done) begin
            nv[ki] <= n_cl;
            if (k == 2'd2) begin
              idx   <= idx + CNT_W'(1);
              state <= S_RD;
            end else begin
              k     <= k + 2'd1;
              state <= S_NRM;
            end
          end
        end
        S_PLANE: begin
          state <= (ady > PLANE_TH) ? S_PDIV : S_FIN;
        end
        S_PDIV: begin
          if (div_done) begin
            d     <= d_cl;
            k     <= '0;
            state <= S_PQ;
          end
        end
        S_PQ: begin
          k <= k + 2'd1;
          if (k != 2'd0) begin
            q[kp] <= sat32(64'(org[kp]) + 64'(prod_a >>> FRAC_BITS));
          end
          if (k == 2'd3) begin
            state <= S_PCHK;
          end
        end
        S_PCHK: begin
          if (pl_ok) begin
            best <= d;
            kind <= KIND_PLANE;
            for (int i = 0; i < 3; i++) begin
              pt[i] <= q[i];
            end
            nv[0] <= '0;
            nv[1] <= 18'(ONE);
            nv[2] <= '0;
            shade <= a_sum[FRAC_BITS+1] ^ nq[FRAC_BITS+1];
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'b00000, hit_dist, shade, mat, nv[2], nv[1], nv[0],
                         pt[2], pt[1], pt[0], hit_flag};
            m_tuser  <= kind;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/rspi_checker.sv
`default_nettype none
`include "ray_sphere_plane_intersect_core_assert.svh"
module rspi_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              m_tvalid,
  input wire logic              m_tready,
  input wire rspi_pkg::m_data_t m_tdata,
  input wire logic [1:0]        m_tuser
);
  import rspi_pkg::*;

  `RSPI_CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")
  `RSPI_CHK_NOW(a_none_zero, m_tvalid && (m_tuser == KIND_NONE), m_tdata[155:0] == '0, "empty result carries hit data")
  `RSPI_CHK_NOW(a_plane_normal, m_tvalid && (m_tuser == KIND_PLANE), (m_tdata[114:97] == '0) && (m_tdata[132:115] == 18'(ONE)) && (m_tdata[150:133] == '0), "plane hit with wrong normal")
  `RSPI_CHK_NOW(a_shade_plane, m_tvalid && (m_tuser != KIND_PLANE), !m_tdata[155], "checker shade set without a plane hit")

endmodule

bind ray_sphere_plane_intersect_core rspi_checker u_rspi_checker (.*);
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rspi_pkg::*;

  typedef struct {
    bit              func;
    bit [2:0]        slot;
    bit signed [31:0] px, py, pz;
    bit signed [17:0] dx, dy, dz;
    bit [30:0]       rad;
    bit [3:0]        mat;
  } cast_item_t;

  typedef struct {
    bit              hit;
    bit [1:0]        kind;
    bit signed [31:0] x, y, z;
    bit signed [17:0] nx, ny, nz;
    bit [3:0]        mat;
    bit              shade;
    bit [30:0]       distance;
  } hit_rec_t;

  class hit_scoreboard;
    longint    cen_x[8], cen_y[8], cen_z[8];
    longint    rad_tab[8];
    bit [3:0]  mat_tab[8];
    int        sphere_count;
    hit_rec_t  pending_hits[$];
    int        errors;

    function longint clampv(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint sat32(longint v);
      return clampv(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function longint unsigned isqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function hit_rec_t nearest_hit(cast_item_t it);
      hit_rec_t h;
      longint o[3], dv[3], pt[3], nv[3], best, c[3], l[3], v[3], q[3];
      longint acc, ll, tca, d2, r2, thc, t, num, d, a, b2, ady;
      longint unsigned ss, len;
      bit sph;
      int cnt;
      h = '{default: 0};
      o = '{longint'(it.px), longint'(it.py), longint'(it.pz)};
      dv = '{longint'(it.dx), longint'(it.dy), longint'(it.dz)};
      pt = '{0, 0, 0};
      nv = '{0, 0, 0};
      best = 0;
      sph = 0;
      cnt = sphere_count > 8 ? 8 : sphere_count;
      for (int i = 0; i < cnt; i++) begin
        c = '{cen_x[i], cen_y[i], cen_z[i]};
        acc = 0;
        ll = 0;
        for (int k = 0; k < 3; k++) begin
          l[k] = sat32(c[k] - o[k]);
          acc += l[k] * dv[k];
          ll += (l[k] * l[k]) >>> FRAC_BITS;
        end
        tca = sat32(acc >>> FRAC_BITS);
        d2 = ll - ((tca * tca) >>> FRAC_BITS);
        if (d2 < 0) d2 = 0;
        r2 = (rad_tab[i] * rad_tab[i]) >>> FRAC_BITS;
        if (d2 > r2) continue;
        thc = longint'(isqrt(longint'(unsigned'(r2 - d2)) << FRAC_BITS));
        t = tca - thc;
        if (t < 0) t = tca + thc;
        if (t < 0) continue;
        if (!sph || t < best) begin
          sph = 1;
          best = t;
          h.kind = KIND_SPHERE;
          h.mat = mat_tab[i];
          ss = 0;
          for (int k = 0; k < 3; k++) begin
            pt[k] = sat32(o[k] + ((t * dv[k]) >>> FRAC_BITS));
            v[k] = sat32(pt[k] - c[k]);
            ss += longint'(unsigned'(v[k] * v[k]));
          end
          len = isqrt(ss);
          for (int k = 0; k < 3; k++)
            nv[k] = len != 0 ? clampv((v[k] * ONE) / longint'(len), N_MIN, N_MAX) : 0;
        end
      end
      ady = dv[1] < 0 ? -dv[1] : dv[1];
      if (ady > PLANE_TH) begin
        num = o[1] + PLANE_Y_OFF;
        d = clampv((-num * ONE) / dv[1], -D_CLAMP, D_CLAMP);
        for (int k = 0; k < 3; k++) q[k] = sat32(o[k] + ((d * dv[k]) >>> FRAC_BITS));
        if (d > 0 && q[0] < X_LIM && q[0] > -X_LIM && q[2] < Z_NEAR && q[2] > Z_FAR &&
            (!sph || d < best)) begin
          a = (q[0] + CHK_OFF) >>> (FRAC_BITS + 1);
          b2 = (-q[2]) >>> (FRAC_BITS + 1);
          best = d;
          h.kind = KIND_PLANE;
          pt = q;
          nv = '{0, clampv(ONE, N_MIN, N_MAX), 0};
          h.shade = a[0] ^ b2[0];
        end
      end
      h.hit = h.kind != KIND_NONE && best < HIT_LIM;
      h.x = 32'(pt[0]);
      h.y = 32'(pt[1]);
      h.z = 32'(pt[2]);
      h.nx = 18'(nv[0]);
      h.ny = 18'(nv[1]);
      h.nz = 18'(nv[2]);
      h.distance = h.kind != KIND_NONE ? 31'(clampv(best, 0, 64'sd2147483647)) : 31'h7fffffff;
      return h;
    endfunction

    function void note_input(cast_item_t it);
      hit_rec_t h;
      h = '{default: 0};
      if (it.func == FUNC_LOAD) begin
        cen_x[it.slot] = longint'(it.px);
        cen_y[it.slot] = longint'(it.py);
        cen_z[it.slot] = longint'(it.pz);
        rad_tab[it.slot] = longint'(it.rad);
        mat_tab[it.slot] = it.mat;
      end else begin
        h = nearest_hit(it);
      end
      pending_hits.push_back(h);
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $error("%s: expected %0d, actual %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(m_data_t d, logic [1:0] u);
      hit_rec_t e;
      if (pending_hits.size() == 0) begin
        $error("result beat with no expected result");
        errors++;
        return;
      end
      e = pending_hits.pop_front();
      cmp("hit", longint'(e.hit), longint'(d[0]));
      cmp("hit_kind", longint'(e.kind), longint'(u));
      cmp("hit_x", longint'(e.x), longint'($signed(d[32:1])));
      cmp("hit_y", longint'(e.y), longint'($signed(d[64:33])));
      cmp("hit_z", longint'(e.z), longint'($signed(d[96:65])));
      cmp("normal_x", longint'(e.nx), longint'($signed(d[114:97])));
      cmp("normal_y", longint'(e.ny), longint'($signed(d[132:115])));
      cmp("normal_z", longint'(e.nz), longint'($signed(d[150:133])));
      cmp("hit_material", longint'(e.mat), longint'(d[154:151]));
      cmp("checker_shade", longint'(e.shade), longint'(d[155]));
      cmp("hit_distance", longint'(e.distance), longint'(d[186:156]));
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      cfg_we;
  logic [3:0] cfg_wdata;
  logic      s_tvalid;
  logic      s_tready;
  s_data_t   s_tdata;
  logic      s_tuser;
  logic      m_tvalid;
  logic      m_tready;
  m_data_t   m_tdata;
  logic [1:0] m_tuser;

  hit_scoreboard sb;
  int send_idle;
  int recv_stall;

  ray_sphere_plane_intersect_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall);
  end

  function automatic int q16(real v);
    return $rtoi(v * 65536.0);
  endfunction

  function automatic int urs(int hi, int off);
    return int'($urandom_range(hi)) - off;
  endfunction

  task automatic send_item(cast_item_t it);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.func;
    s_tdata <= {4'b0, it.mat, it.rad, it.dz, it.dy, it.dx, it.pz, it.py, it.px, it.slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= 4'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.sphere_count = v;
  endtask

  task automatic load_sphere(int slot, longint cx, longint cy, longint cz, longint r, int m);
    cast_item_t it;
    it = '{default: 0};
    it.func = FUNC_LOAD;
    it.slot = 3'(slot);
    it.px = 32'(cx);
    it.py = 32'(cy);
    it.pz = 32'(cz);
    it.rad = 31'(r);
    it.mat = 4'(m);
    send_item(it);
  endtask

  task automatic shoot_ray(longint ox, longint oy, longint oz, int dx, int dy, int dz);
    cast_item_t it;
    it = '{default: 0};
    it.func = FUNC_RAY;
    it.px = 32'(ox);
    it.py = 32'(oy);
    it.pz = 32'(oz);
    it.dx = 18'(dx);
    it.dy = 18'(dy);
    it.dz = 18'(dz);
    it.slot = 3'($urandom);
    it.rad = 31'($urandom);
    it.mat = 4'($urandom);
    send_item(it);
  endtask

  task automatic aimed_ray(real ox, real oy, real oz, real tx, real ty, real tz);
    real vx, vy, vz, n;
    vx = tx - ox;
    vy = ty - oy;
    vz = tz - oz;
    n = $sqrt(vx * vx + vy * vy + vz * vz);
    if (n < 1.0e-6) begin
      vz = -1.0;
      n = 1.0;
    end
    shoot_ray(q16(ox), q16(oy), q16(oz), q16(vx / n), q16(vy / n), q16(vz / n));
  endtask

  task automatic scene_sphere(int slot);
    load_sphere(slot, q16(urs(1200, 600) / 100.0),
                q16(urs(1000, 600) / 100.0),
                q16(-(urs(2500, 0) + 500) / 100.0),
                q16((urs(350, 0) + 50) / 100.0), urs(15, 0));
  endtask

  task automatic random_item();
    cast_item_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      scene_sphere(urs(7, 0));
    end else if (pick < 80) begin
      aimed_ray(urs(400, 200) / 100.0, urs(400, 200) / 100.0,
                urs(400, 200) / 100.0,
                urs(2400, 1200) / 100.0, urs(1000, 700) / 100.0,
                -(urs(2500, 0) + 500) / 100.0);
    end else if (pick < 85) begin
      shoot_ray(q16(urs(200, 100) / 100.0), 0, 0,
                $urandom_range(1) ? 65536 : -65536, urs(130, 65), 0);
    end else begin
      it.func = 1'($urandom);
      it.slot = 3'($urandom);
      it.px = $urandom;
      it.py = $urandom;
      it.pz = $urandom;
      it.dx = 18'(urs(131072, 65536));
      it.dy = 18'(urs(131072, 65536));
      it.dz = 18'(urs(131072, 65536));
      it.rad = 31'($urandom);
      it.mat = 4'($urandom);
      send_item(it);
    end
  endtask

  initial begin
    int counts[4];
    int idles[4];
    int stalls[4];
    sb = new();
    counts = '{2, 15, 1, 0};
    idles = '{0, 55, 0, 34};
    stalls = '{0, 0, 55, 34};
    send_idle = 0;
    recv_stall = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    shoot_ray(0, 0, 0, 0, 0, -65536);
    load_sphere(0, 0, 0, q16(-20.0), q16(3.0), 5);
    load_sphere(1, q16(5.0), q16(5.0), q16(5.0), 0, 15);
    load_sphere(2, 0, 0, q16(-1500.0), q16(10.0), 9);
    load_sphere(3, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 31'h7fffffff, 0);
    load_sphere(4, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 1, 1);
    for (int s = 5; s < 8; s++) scene_sphere(s);
    write_count(3);
    shoot_ray(0, 0, 0, 0, 0, -65536);
    shoot_ray(q16(5.0), q16(5.0), q16(5.0), 0, 0, 65536);
    shoot_ray(0, 0, q16(-1000.0), 0, 0, -65536);
    aimed_ray(0.0, 0.0, 0.0, 3.0, -4.0, -20.0);
    shoot_ray(0, 0, 0, 65536, 65, 0);
    shoot_ray(0, 0, 0, 0, -66, -65536);
    write_count(8);
    shoot_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, -65536, -65536, -65536);
    shoot_ray(64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 65536, 65536, 65536);
    aimed_ray(0.0, 0.0, 0.0, -8.0, -4.0, -25.0);
    for (int s = 0; s < 8; s++) scene_sphere(s);

    for (int p = 0; p < 4; p++) begin
      write_count(counts[p]);
      send_idle = idles[p];
      recv_stall = stalls[p];
      for (int n = 0; n < 170; n++) begin
        if (p == 1 && n == 80) drain();
        random_item();
      end
    end
    drain();
    repeat (3000) @(posedge clk);
    if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
